FILE: hdl/poi_pkg.sv
// Shared types, constants and the control program of the planar odometry integrator.
package poi_pkg;

   localparam int TRIG_ITERATIONS = 16;
   localparam int TRIG_STEPS = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
   localparam int ITER_W = $clog2(TRIG_STEPS);
   localparam int ATAN_IDX_W = 5;

   localparam int DT_W = 20;
   localparam int VEL_W = 24;
   localparam int YAW_W = 32;
   localparam int POS_W = 32;
   localparam int ANGLE_W = 32;
   localparam int QUAT_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int TRIG_W = 34;
   localparam int MUL_A_W = 43;
   localparam int MUL_B_W = 25;
   localparam int PROD_W = MUL_A_W + MUL_B_W;
   localparam int ACC_W = 57;
   localparam int RATE_SHIFT = 14;
   localparam int RATE_W = ACC_W - RATE_SHIFT;
   localparam int DISP_SHIFT = 32;
   localparam int DISP_W = PROD_W - DISP_SHIFT;
   localparam int HEAD_SHIFT = 16;
   localparam int QUAT_SHIFT = 15;

   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);
   localparam logic [ANGLE_W-1:0] ANGLE_EIGHTH = 32'h2000_0000;

   localparam logic signed [VEL_W-1:0] VEL_FORWARD_RESET = VEL_W'(6554);
   localparam logic signed [VEL_W-1:0] VEL_LATERAL_RESET = -VEL_W'(6554);
   localparam logic signed [YAW_W-1:0] YAW_RATE_RESET = YAW_W'(68356505);

   localparam logic [ANGLE_W-1:0] ATAN_TURNS [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   localparam logic [CSR_INDEX_W-1:0] CSR_VEL_FORWARD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VEL_LATERAL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_YAW_RATE = 2'd2;

   typedef enum logic [1:0] {
      QUAD_EAST,
      QUAD_NORTH,
      QUAD_WEST,
      QUAD_SOUTH
   } quad_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_FWD_COS,
      MUL_LAT_SIN,
      MUL_FWD_SIN,
      MUL_LAT_COS,
      MUL_RATE_DT,
      MUL_YAW_DT
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [1:0] {
      POS_HOLD,
      POS_X,
      POS_Y
   } pos_op_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_TRIG_BUSY,
      COND_OUT_FULL
   } cond_type;

   typedef enum logic {
      TRIG_HEADING,
      TRIG_HALF
   } trig_src_type;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_TRIG_WAIT = 4'd1;
   localparam logic [STEP_W-1:0] STEP_HALF_WAIT = 4'd12;
   localparam logic [STEP_W-1:0] STEP_EMIT = 4'd13;

   typedef struct packed {
      logic trig_start;
      trig_src_type trig_src;
      mul_sel_type mul_sel;
      acc_op_type acc_op;
      logic rate_ld;
      pos_op_type pos_op;
      logic head_ld;
      logic out_ld;
      cond_type cond;
      logic [STEP_W-1:0] jump_to;
      logic last;
   } ctrl_word_type;

   typedef struct packed {
      logic trig_busy;
      logic out_full;
   } status_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] vel_forward;
      logic signed [VEL_W-1:0] vel_lateral;
      logic signed [YAW_W-1:0] yaw_rate;
   } cfg_type;

   localparam ctrl_word_type CW_NOP = '{
      trig_start: 1'b0,
      trig_src: TRIG_HEADING,
      mul_sel: MUL_NONE,
      acc_op: ACC_HOLD,
      rate_ld: 1'b0,
      pos_op: POS_HOLD,
      head_ld: 1'b0,
      out_ld: 1'b0,
      cond: COND_NONE,
      jump_to: '0,
      last: 1'b0
   };

   // The control program, one word per step.
   function automatic ctrl_word_type poi_ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw = CW_NOP;
      case (step)
         4'd0: begin
            cw.trig_start = 1'b1;
            cw.trig_src = TRIG_HEADING;
         end
         STEP_TRIG_WAIT: begin
            cw.cond = COND_TRIG_BUSY;
            cw.jump_to = STEP_TRIG_WAIT;
         end
         4'd2: begin
            cw.mul_sel = MUL_FWD_COS;
         end
         4'd3: begin
            cw.mul_sel = MUL_LAT_SIN;
            cw.acc_op = ACC_LOAD;
         end
         4'd4: begin
            cw.mul_sel = MUL_FWD_SIN;
            cw.acc_op = ACC_SUB;
         end
         4'd5: begin
            cw.mul_sel = MUL_LAT_COS;
            cw.acc_op = ACC_LOAD;
            cw.rate_ld = 1'b1;
         end
         4'd6: begin
            cw.mul_sel = MUL_RATE_DT;
            cw.acc_op = ACC_ADD;
         end
         4'd7: begin
            cw.pos_op = POS_X;
            cw.rate_ld = 1'b1;
         end
         4'd8: begin
            cw.mul_sel = MUL_RATE_DT;
         end
         4'd9: begin
            cw.pos_op = POS_Y;
            cw.mul_sel = MUL_YAW_DT;
         end
         4'd10: begin
            cw.head_ld = 1'b1;
         end
         4'd11: begin
            cw.trig_start = 1'b1;
            cw.trig_src = TRIG_HALF;
         end
         STEP_HALF_WAIT: begin
            cw.cond = COND_TRIG_BUSY;
            cw.jump_to = STEP_HALF_WAIT;
         end
         STEP_EMIT: begin
            cw.cond = COND_OUT_FULL;
            cw.jump_to = STEP_EMIT;
            cw.out_ld = 1'b1;
            cw.last = 1'b1;
         end
         default: begin
            cw = CW_NOP;
         end
      endcase
      return cw;
   endfunction

   // Rounds a Q4.30 value to Q1.15 and saturates it.
   function automatic logic signed [QUAT_W-1:0] poi_to_q15(input logic signed [TRIG_W-1:0] v);
      logic signed [TRIG_W-1:0] rsum;
      logic signed [TRIG_W-QUAT_SHIFT-1:0] r;
      logic signed [QUAT_W-1:0] q;
      rsum = v + TRIG_W'(1 << (QUAT_SHIFT - 1));
      r = rsum[TRIG_W-1:QUAT_SHIFT];
      if (r > (TRIG_W-QUAT_SHIFT)'(32767)) begin
         q = QUAT_W'(32767);
      end else if (r < -(TRIG_W-QUAT_SHIFT)'(32768)) begin
         q = -QUAT_W'(32768);
      end else begin
         q = r[QUAT_W-1:0];
      end
      return q;
   endfunction

endpackage

FILE: hdl/poi_req_if.sv
// Tick channel carrying the elapsed time.
interface poi_req_if import poi_pkg::*; ();
   logic valid;
   logic ready;
   logic [DT_W-1:0] elapsed_time;

   modport source (output valid, output elapsed_time, input ready);
   modport sink (input valid, input elapsed_time, output ready);
endinterface

FILE: hdl/poi_rsp_if.sv
// Pose channel carrying position, heading and yaw quaternion.
interface poi_rsp_if import poi_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic [ANGLE_W-1:0] heading;
   logic signed [QUAT_W-1:0] quat_z;
   logic signed [QUAT_W-1:0] quat_w;

   modport source (output valid, output pos_x, output pos_y, output heading,
                   output quat_z, output quat_w, input ready);
   modport sink (input valid, input pos_x, input pos_y, input heading,
                 input quat_z, input quat_w, output ready);
endinterface

FILE: hdl/poi_csr_if.sv
// Configuration write channel.
interface poi_csr_if import poi_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/poi_cordic.sv
// Iterative CORDIC sine/cosine unit, one rotation step per cycle.
module poi_cordic import poi_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [ANGLE_W-1:0] angle,
   output logic busy,
   output logic signed [TRIG_W-1:0] cos_q30,
   output logic signed [TRIG_W-1:0] sin_q30
);

   logic busy_ff, busy_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   quad_type quad_ff, quad_in;
   logic signed [TRIG_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [TRIG_W-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic [ANGLE_W-1:0] angle_bias, angle_rem;
   logic signed [TRIG_W-1:0] dx, dy, step_angle, x_next, y_next, z_next;

   always_comb begin
      angle_bias = angle + ANGLE_EIGHTH;
      angle_rem = angle - {angle_bias[ANGLE_W-1 -: 2], {(ANGLE_W-2){1'b0}}};
      dx = y_ff >>> iter_ff;
      dy = x_ff >>> iter_ff;
      step_angle = signed'(TRIG_W'(ATAN_TURNS[ATAN_IDX_W'(iter_ff)]));
      if (!z_ff[TRIG_W-1]) begin
         x_next = x_ff - dx;
         y_next = y_ff + dy;
         z_next = z_ff - step_angle;
      end else begin
         x_next = x_ff + dx;
         y_next = y_ff - dy;
         z_next = z_ff + step_angle;
      end

      busy_in = busy_ff;
      iter_in = iter_ff;
      quad_in = quad_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      cos_in = cos_ff;
      sin_in = sin_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         quad_in = quad_type'(angle_bias[ANGLE_W-1 -: 2]);
         x_in = CORDIC_GAIN;
         y_in = '0;
         z_in = TRIG_W'(signed'(angle_rem));
      end else if (busy_ff) begin
         x_in = x_next;
         y_in = y_next;
         z_in = z_next;
         iter_in = iter_ff + ITER_W'(1);
         if (iter_ff == ITER_W'(TRIG_STEPS - 1)) begin
            busy_in = 1'b0;
            case (quad_ff)
               QUAD_EAST: begin
                  cos_in = x_next;
                  sin_in = y_next;
               end
               QUAD_NORTH: begin
                  cos_in = -y_next;
                  sin_in = x_next;
               end
               QUAD_WEST: begin
                  cos_in = -x_next;
                  sin_in = -y_next;
               end
               QUAD_SOUTH: begin
                  cos_in = y_next;
                  sin_in = -x_next;
               end
               default: begin
                  cos_in = x_next;
                  sin_in = y_next;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
         cos_ff <= '0;
         sin_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         iter_ff <= iter_in;
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
      quad_ff <= quad_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign busy = busy_ff;
   assign cos_q30 = cos_ff;
   assign sin_q30 = sin_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("trig unit did not go busy on start");
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && !start) |=> ($stable(cos_ff) && $stable(sin_ff)))
      else $error("trig result changed while idle");
   a_iter_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (iter_ff <= ITER_W'(TRIG_STEPS - 1)))
      else $error("trig iteration count out of range");

endmodule

FILE: hdl/poi_sequencer.sv
// Step counter and control store that drive the odometry datapath.
module poi_sequencer import poi_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  status_type status,
   output ctrl_word_type cw,
   output logic busy
);

   logic busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ctrl_word_type rom_word;
   logic hold;

   always_comb begin
      rom_word = poi_ucode(step_ff);
      hold = busy_ff && (((rom_word.cond == COND_TRIG_BUSY) && status.trig_busy) ||
                         ((rom_word.cond == COND_OUT_FULL) && status.out_full));
      cw = (busy_ff && !hold) ? rom_word : CW_NOP;

      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         if (hold) begin
            step_in = rom_word.jump_to;
         end else if (rom_word.last) begin
            busy_in = 1'b0;
            step_in = '0;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign busy = busy_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("transaction started while sequencer busy");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= STEP_EMIT)) else $error("step counter ran past program");
   a_trig_free: assert property (@(posedge clock) disable iff (reset)
      cw.trig_start |-> !status.trig_busy) else $error("trig unit started while busy");

endmodule

FILE: hdl/poi_datapath.sv
// Shared multiplier, accumulator and pose registers of the integrator.
module poi_datapath import poi_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  ctrl_word_type cw,
   input  cfg_type cfg,
   input  logic [DT_W-1:0] dt,
   input  logic signed [TRIG_W-1:0] cos_q30,
   input  logic signed [TRIG_W-1:0] sin_q30,
   output logic [ANGLE_W-1:0] trig_angle,
   output logic signed [POS_W-1:0] pos_x,
   output logic signed [POS_W-1:0] pos_y,
   output logic [ANGLE_W-1:0] heading
);

   localparam logic signed [POS_W:0] POS_HI = {2'b00, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W:0] POS_LO = {2'b11, {(POS_W-1){1'b0}}};

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, acc_round, prod_short;
   logic signed [RATE_W-1:0] rate_ff, rate_in;
   logic signed [PROD_W-1:0] disp_round, head_round;
   logic signed [DISP_W-1:0] disp;
   logic signed [POS_W:0] pos_sum;
   logic signed [POS_W-1:0] pos_base, pos_sat;
   logic signed [POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [ANGLE_W-1:0] heading_ff, heading_in;

   always_comb begin
      case (cw.mul_sel)
         MUL_FWD_COS: begin
            mul_a = MUL_A_W'(cos_q30);
            mul_b = MUL_B_W'(cfg.vel_forward);
         end
         MUL_LAT_SIN: begin
            mul_a = MUL_A_W'(sin_q30);
            mul_b = MUL_B_W'(cfg.vel_lateral);
         end
         MUL_FWD_SIN: begin
            mul_a = MUL_A_W'(sin_q30);
            mul_b = MUL_B_W'(cfg.vel_forward);
         end
         MUL_LAT_COS: begin
            mul_a = MUL_A_W'(cos_q30);
            mul_b = MUL_B_W'(cfg.vel_lateral);
         end
         MUL_RATE_DT: begin
            mul_a = rate_ff;
            mul_b = signed'(MUL_B_W'(dt));
         end
         MUL_YAW_DT: begin
            mul_a = MUL_A_W'(cfg.yaw_rate);
            mul_b = signed'(MUL_B_W'(dt));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = (cw.mul_sel == MUL_NONE) ? prod_ff : mul_a * mul_b;

      prod_short = prod_ff[ACC_W-1:0];
      case (cw.acc_op)
         ACC_LOAD: acc_in = prod_short;
         ACC_ADD:  acc_in = acc_ff + prod_short;
         ACC_SUB:  acc_in = acc_ff - prod_short;
         default:  acc_in = acc_ff;
      endcase

      acc_round = acc_ff + ACC_W'(1 << (RATE_SHIFT - 1));
      rate_in = cw.rate_ld ? acc_round[ACC_W-1:RATE_SHIFT] : rate_ff;

      disp_round = prod_ff + (PROD_W'(1) << (DISP_SHIFT - 1));
      disp = disp_round[PROD_W-1:DISP_SHIFT];
      pos_base = (cw.pos_op == POS_Y) ? pos_y_ff : pos_x_ff;
      pos_sum = (POS_W+1)'(pos_base) + (POS_W+1)'(disp);
      if (pos_sum > POS_HI) begin
         pos_sat = POS_HI[POS_W-1:0];
      end else if (pos_sum < POS_LO) begin
         pos_sat = POS_LO[POS_W-1:0];
      end else begin
         pos_sat = pos_sum[POS_W-1:0];
      end
      pos_x_in = (cw.pos_op == POS_X) ? pos_sat : pos_x_ff;
      pos_y_in = (cw.pos_op == POS_Y) ? pos_sat : pos_y_ff;

      head_round = prod_ff + PROD_W'(1 << (HEAD_SHIFT - 1));
      heading_in = cw.head_ld ?
                   heading_ff + head_round[HEAD_SHIFT+ANGLE_W-1:HEAD_SHIFT] : heading_ff;

      trig_angle = (cw.trig_src == TRIG_HALF) ?
                   {1'b0, heading_ff[ANGLE_W-1:1]} : heading_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         heading_ff <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         heading_ff <= heading_in;
      end
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      rate_ff <= rate_in;
   end

   assign pos_x = pos_x_ff;
   assign pos_y = pos_y_ff;
   assign heading = heading_ff;

endmodule

FILE: hdl/planar_odometry_integrator.sv
// Top level of the planar dead-reckoning pose integrator.
// Usage: each transaction on req_if carries the time elapsed since the previous
// tick. The block rotates the configured body-frame velocity by the current
// heading, integrates x and y with saturation, then advances the heading by
// yaw_rate times the elapsed time. One transaction on rsp_if follows each tick
// with the new position, heading and yaw quaternion.
// The csr_if channel writes vel_forward, vel_lateral and yaw_rate; it is always
// ready and should be used only while no tick is in flight.
// req_if is not ready while a tick is in progress. It is ready again in the cycle the
// result appears, so a new tick is accepted only after the previous result has been
// loaded into the output register. Each tick makes two passes through the iterative
// CORDIC unit, one rotation step per cycle, plus the shared multiplier steps of the
// program.
// A finished result waits in an output register, so the next tick is accepted
// while the receiver stalls; a second result waits until rsp_if has taken it.
// Reset clears position and heading to zero and restores the default velocities.
module planar_odometry_integrator import poi_pkg::*; (
   input  logic clock,
   input  logic reset,
   poi_req_if.sink req_if,
   poi_rsp_if.source rsp_if,
   poi_csr_if.sink csr_if
);

   cfg_type cfg_ff, cfg_in;
   logic [DT_W-1:0] dt_ff, dt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] rsp_pos_x_ff, rsp_pos_x_in, rsp_pos_y_ff, rsp_pos_y_in;
   logic [ANGLE_W-1:0] rsp_heading_ff, rsp_heading_in;
   logic signed [QUAT_W-1:0] rsp_quat_z_ff, rsp_quat_z_in, rsp_quat_w_ff, rsp_quat_w_in;

   logic req_accept;
   logic seq_busy;
   logic trig_busy;
   status_type status;
   ctrl_word_type cw;
   logic signed [TRIG_W-1:0] cos_q30, sin_q30;
   logic [ANGLE_W-1:0] trig_angle;
   logic signed [POS_W-1:0] pos_x, pos_y;
   logic [ANGLE_W-1:0] heading;

   assign req_if.ready = !seq_busy;
   assign req_accept = req_if.valid && !seq_busy;
   assign csr_if.ready = 1'b1;

   assign status.trig_busy = trig_busy;
   assign status.out_full = rsp_valid_ff && !rsp_if.ready;

   poi_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .status (status),
      .cw     (cw),
      .busy   (seq_busy)
   );

   poi_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cw.trig_start),
      .angle   (trig_angle),
      .busy    (trig_busy),
      .cos_q30 (cos_q30),
      .sin_q30 (sin_q30)
   );

   poi_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cw         (cw),
      .cfg        (cfg_ff),
      .dt         (dt_ff),
      .cos_q30    (cos_q30),
      .sin_q30    (sin_q30),
      .trig_angle (trig_angle),
      .pos_x      (pos_x),
      .pos_y      (pos_y),
      .heading    (heading)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_VEL_FORWARD: cfg_in.vel_forward = csr_if.data[VEL_W-1:0];
            CSR_VEL_LATERAL: cfg_in.vel_lateral = csr_if.data[VEL_W-1:0];
            CSR_YAW_RATE:    cfg_in.yaw_rate = csr_if.data[YAW_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end

      dt_in = req_accept ? req_if.elapsed_time : dt_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_pos_x_in = rsp_pos_x_ff;
      rsp_pos_y_in = rsp_pos_y_ff;
      rsp_heading_in = rsp_heading_ff;
      rsp_quat_z_in = rsp_quat_z_ff;
      rsp_quat_w_in = rsp_quat_w_ff;
      if (cw.out_ld) begin
         rsp_valid_in = 1'b1;
         rsp_pos_x_in = pos_x;
         rsp_pos_y_in = pos_y;
         rsp_heading_in = heading;
         rsp_quat_z_in = poi_to_q15(sin_q30);
         rsp_quat_w_in = poi_to_q15(cos_q30);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vel_forward <= VEL_FORWARD_RESET;
         cfg_ff.vel_lateral <= VEL_LATERAL_RESET;
         cfg_ff.yaw_rate <= YAW_RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dt_ff <= dt_in;
      rsp_pos_x_ff <= rsp_pos_x_in;
      rsp_pos_y_ff <= rsp_pos_y_in;
      rsp_heading_ff <= rsp_heading_in;
      rsp_quat_z_ff <= rsp_quat_z_in;
      rsp_quat_w_ff <= rsp_quat_w_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.pos_x = rsp_pos_x_ff;
   assign rsp_if.pos_y = rsp_pos_y_ff;
   assign rsp_if.heading = rsp_heading_ff;
   assign rsp_if.quat_z = rsp_quat_z_ff;
   assign rsp_if.quat_w = rsp_quat_w_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cw.out_ld |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("result loaded over a pending transaction");
   a_quat_ready: assert property (@(posedge clock) disable iff (reset)
      cw.out_ld |-> !trig_busy) else $error("result loaded while trig unit busy");
   a_program_start: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> cw.trig_start) else $error("program did not start after tick");

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the planar odometry integrator: pose prediction and pose checks.
module tb_top;
   import poi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TICK_LATENCY = 2 * TRIG_STEPS + 14;
   localparam int CYCLE_LIMIT = 800_000;
   localparam int PRINT_LIMIT = 40;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [DT_W-1:0] DT_MAX = '1;
   localparam logic [DT_W-1:0] DT_ONE_SECOND = 20'h10000;

   typedef enum int {
      SET_RANDOM,
      SET_EXTREME,
      SET_SPIN,
      SET_CRAWL,
      SET_SPRINT
   } setting_kind_type;

   typedef struct {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [ANGLE_W-1:0] heading;
      logic signed [QUAT_W-1:0] quat_z;
      logic signed [QUAT_W-1:0] quat_w;
   } pose_type;

   logic clock;
   logic reset;
   logic no_idle;

   poi_req_if req_bus ();
   poi_rsp_if rsp_bus ();
   poi_csr_if csr_bus ();

   planar_odometry_integrator uut (
      .clock(clock),
      .reset(reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .csr_if(csr_bus)
   );

   logic signed [VEL_W-1:0] fwd_vel;
   logic signed [VEL_W-1:0] lat_vel;
   logic signed [YAW_W-1:0] spin_rate;
   longint track_x;
   longint track_y;
   logic [ANGLE_W-1:0] track_heading;

   pose_type pending_poses[$];
   int poses_checked;
   int reg_writes;
   int clamp_count;
   int wrap_count;
   int mismatch_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint round_shr(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint saturate_pos(input longint v);
      longint lo;
      longint hi;
      lo = -(longint'(1) << (POS_W - 1));
      hi = (longint'(1) << (POS_W - 1)) - 1;
      if (v < lo || v > hi) begin
         clamp_count++;
      end
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [QUAT_W-1:0] q30_to_q15(input longint v);
      longint r;
      r = round_shr(v, QUAT_SHIFT);
      if (r > 32767) begin
         r = 32767;
      end else if (r < -32768) begin
         r = -32768;
      end
      return r[QUAT_W-1:0];
   endfunction

   function automatic void cordic_sincos(input logic [ANGLE_W-1:0] angle,
                                         output longint cos_q30, output longint sin_q30);
      logic [ANGLE_W-1:0] shifted;
      logic [ANGLE_W-1:0] resid;
      quad_type quad;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      shifted = angle + ANGLE_EIGHTH;
      quad = quad_type'(shifted[ANGLE_W-1:ANGLE_W-2]);
      resid = angle - {shifted[ANGLE_W-1:ANGLE_W-2], 30'd0};
      z = longint'($signed(resid));
      x = longint'(CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < TRIG_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(ATAN_TURNS[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(ATAN_TURNS[i]);
         end
      end
      case (quad)
         QUAD_EAST: begin
            cos_q30 = x;
            sin_q30 = y;
         end
         QUAD_NORTH: begin
            cos_q30 = -y;
            sin_q30 = x;
         end
         QUAD_WEST: begin
            cos_q30 = -x;
            sin_q30 = -y;
         end
         default: begin
            cos_q30 = y;
            sin_q30 = -x;
         end
      endcase
   endfunction

   function automatic longint travel(input longint rate_q46, input logic [DT_W-1:0] dt);
      longint rate;
      rate = round_shr(rate_q46, RATE_SHIFT);
      return round_shr(rate * longint'(dt), DISP_SHIFT);
   endfunction

   function automatic pose_type integrate_tick(input logic [DT_W-1:0] dt);
      longint c;
      longint s;
      longint hc;
      longint hs;
      longint fwd;
      longint lat;
      longint turn;
      longint unwrapped;
      pose_type pose;
      fwd = longint'(fwd_vel);
      lat = longint'(lat_vel);
      cordic_sincos(track_heading, c, s);
      track_x = saturate_pos(track_x + travel(fwd * c - lat * s, dt));
      track_y = saturate_pos(track_y + travel(fwd * s + lat * c, dt));
      turn = round_shr(longint'(spin_rate) * longint'(dt), HEAD_SHIFT);
      unwrapped = longint'(track_heading) + turn;
      if (unwrapped < 0 || unwrapped >= (longint'(1) << ANGLE_W)) begin
         wrap_count++;
      end
      track_heading = track_heading + turn[ANGLE_W-1:0];
      cordic_sincos(track_heading >> 1, hc, hs);
      pose.pos_x = track_x[POS_W-1:0];
      pose.pos_y = track_y[POS_W-1:0];
      pose.heading = track_heading;
      pose.quat_z = q30_to_q15(hs);
      pose.quat_w = q30_to_q15(hc);
      return pose;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      pose_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_poses.size() == 0) begin
            report_mismatch("unexpected pose transaction", rsp_bus.pos_x, 0);
         end else begin
            want = pending_poses.pop_front();
            poses_checked++;
            if (rsp_bus.pos_x !== want.pos_x) begin
               report_mismatch("pos_x", rsp_bus.pos_x, want.pos_x);
            end
            if (rsp_bus.pos_y !== want.pos_y) begin
               report_mismatch("pos_y", rsp_bus.pos_y, want.pos_y);
            end
            if (rsp_bus.heading !== want.heading) begin
               report_mismatch("heading", rsp_bus.heading, want.heading);
            end
            if (rsp_bus.quat_z !== want.quat_z) begin
               report_mismatch("quat_z", rsp_bus.quat_z, want.quat_z);
            end
            if (rsp_bus.quat_w !== want.quat_w) begin
               report_mismatch("quat_w", rsp_bus.quat_w, want.quat_w);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= no_idle || ($urandom_range(99) >= 25);
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timed out after %0d cycles with %0d poses outstanding.",
               cycles, pending_poses.size());
      $display("FAILURE");
      $finish;
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_VEL_FORWARD: fwd_vel = value[VEL_W-1:0];
         CSR_VEL_LATERAL: lat_vel = value[VEL_W-1:0];
         CSR_YAW_RATE: spin_rate = value[YAW_W-1:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_tick(input logic [DT_W-1:0] dt);
      int gap;
      if (!no_idle && $urandom_range(99) < 8) begin
         gap = $urandom_range(1, TICK_LATENCY + 20);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      while (!no_idle && $urandom_range(99) < 25) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.elapsed_time <= dt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      pending_poses.push_back(integrate_tick(dt));
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_poses.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [DT_W-1:0] pick_elapsed(input bit long_ticks);
      int pick;
      pick = $urandom_range(9);
      if (long_ticks) begin
         return (pick == 0) ? DT_MAX : DT_W'($urandom_range(20'hC0000, 20'hFFFFF));
      end
      case (pick)
         0: return '0;
         1: return DT_MAX;
         2: return DT_W'($urandom_range(255));
         default: return DT_W'($urandom());
      endcase
   endfunction

   task automatic program_setting(input setting_kind_type kind);
      logic [CSR_DATA_W-1:0] junk_a;
      logic [CSR_DATA_W-1:0] junk_b;
      logic [CSR_DATA_W-1:0] yaw_v;
      logic [VEL_W-1:0] fwd_v;
      logic [VEL_W-1:0] lat_v;
      int small_v;
      junk_a = $urandom();
      junk_b = $urandom();
      fwd_v = VEL_W'($urandom());
      lat_v = VEL_W'($urandom());
      yaw_v = $urandom();
      case (kind)
         SET_EXTREME: begin
            fwd_v = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            lat_v = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            yaw_v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         end
         SET_SPIN: begin
            fwd_v = '0;
            lat_v = '0;
         end
         SET_CRAWL: begin
            small_v = int'($urandom_range(2048)) - 1024;
            fwd_v = small_v[VEL_W-1:0];
            small_v = int'($urandom_range(2048)) - 1024;
            lat_v = small_v[VEL_W-1:0];
            small_v = int'($urandom_range(2_000_000)) - 1_000_000;
            yaw_v = small_v;
         end
         SET_SPRINT: begin
            fwd_v = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            lat_v = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            small_v = int'($urandom_range(2_000_000)) - 1_000_000;
            yaw_v = small_v;
         end
         default: ;
      endcase
      if ($urandom_range(3) == 0) begin
         write_reg(CSR_UNUSED, $urandom());
      end
      write_reg(CSR_VEL_FORWARD, {junk_a[CSR_DATA_W-1:VEL_W], fwd_v});
      write_reg(CSR_VEL_LATERAL, {junk_b[CSR_DATA_W-1:VEL_W], lat_v});
      write_reg(CSR_YAW_RATE, yaw_v);
   endtask

   task automatic test_default_motion();
      send_tick('0);
      send_tick(20'd1);
      send_tick(DT_MAX);
   endtask

   task automatic test_heading_wrap();
      wait_idle();
      write_reg(CSR_YAW_RATE, 32'h8000_0000);
      send_tick(20'd1);
      send_tick(DT_MAX);
      wait_idle();
      write_reg(CSR_YAW_RATE, 32'h7FFF_FFFF);
      send_tick(DT_MAX);
      wait_idle();
      write_reg(CSR_YAW_RATE, -track_heading);
      send_tick(DT_ONE_SECOND);
      wait_idle();
      write_reg(CSR_YAW_RATE, 32'h4000_0000);
      repeat (4) send_tick(DT_ONE_SECOND);
   endtask

   task automatic test_unused_bits();
      wait_idle();
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      write_reg(CSR_VEL_FORWARD, 32'hA57F_FFFF);
      write_reg(CSR_VEL_LATERAL, 32'h5A80_0000);
      send_tick(DT_MAX);
   endtask

   task automatic test_position_clamp();
      wait_idle();
      write_reg(CSR_YAW_RATE, '0);
      repeat (17) send_tick(DT_MAX);
   endtask

   task automatic test_random_settings();
      setting_kind_type kind;
      int count;
      for (int phase = 0; phase < 22; phase++) begin
         kind = setting_kind_type'(phase % 5);
         wait_idle();
         program_setting(kind);
         count = (kind == SET_SPRINT) ? 70 : $urandom_range(35, 65);
         repeat (count) send_tick(pick_elapsed(kind == SET_SPRINT));
      end
   endtask

   task automatic test_back_to_back();
      wait_idle();
      program_setting(SET_RANDOM);
      no_idle <= 1'b1;
      repeat (120) send_tick(pick_elapsed(1'b0));
      wait_idle();
      no_idle <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      no_idle = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.elapsed_time = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      fwd_vel = VEL_FORWARD_RESET;
      lat_vel = VEL_LATERAL_RESET;
      spin_rate = YAW_RATE_RESET;
      track_x = 0;
      track_y = 0;
      track_heading = '0;
      poses_checked = 0;
      reg_writes = 0;
      clamp_count = 0;
      wrap_count = 0;
      mismatch_count = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_motion();
      test_heading_wrap();
      test_unused_bits();
      test_position_clamp();
      test_random_settings();
      test_back_to_back();

      wait_idle();
      repeat (TICK_LATENCY + 10) @(negedge clock);
      $display("Checked %0d poses across %0d register writes.", poses_checked, reg_writes);
      $display("Predicted %0d position clamps and %0d heading wraps; %0d field mismatches.",
               clamp_count, wrap_count, mismatch_count);
      if (mismatch_count == 0 && pending_poses.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: planar_odometry_integrator.f
hdl/poi_pkg.sv
hdl/poi_req_if.sv
hdl/poi_rsp_if.sv
hdl/poi_csr_if.sv
hdl/poi_cordic.sv
hdl/poi_sequencer.sv
hdl/poi_datapath.sv
hdl/planar_odometry_integrator.sv
bench/tb_top.sv
